### src/rbsi_pkg.sv
package rbsi_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int WH_WIDTH    = 31;
    localparam logic [WH_WIDTH-1:0] WH_RESET = WH_WIDTH'(2) << FRAC_BITS;

    localparam int NAXES  = 3;
    localparam int AXIS_X = 0;
    localparam int AXIS_Y = 1;
    localparam int AXIS_Z = 2;

    // input field positions in s_axis_tdata, in units of COORD_WIDTH
    localparam int F_END_X     = 3;
    localparam int F_BOX_MIN_X = 6;
    localparam int F_BOX_MIN_Z = 7;
    localparam int F_BOX_MAX_X = 8;
    localparam int F_BOX_MAX_Z = 9;
    localparam int NUM_IN_FIELDS = 10;

    localparam int IN_BITS  = NUM_IN_FIELDS * COORD_WIDTH;
    localparam int OUT_BITS = NAXES * COORD_WIDTH;

    localparam int TW = COORD_WIDTH + 1;  // t numerator / denominator
    localparam int XW = 2 * TW + 1;       // cross product
    localparam int PW = 2 * TW;           // |d| * t numerator
    localparam int NW = PW + 1;           // rounded dividend
    localparam int QW = TW;               // quotient
    localparam int RW = TW + 1;           // divisor and remainder

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [TW-1:0]          t_tnum;
    typedef logic [TW-1:0]                 t_tden;

    typedef struct packed {
        t_coord [NAXES-1:0] o;
        t_tnum  [NAXES-1:0] d;
        t_tnum  [NAXES-1:0] en;
        t_tnum  [NAXES-1:0] ex;
        t_tden  [NAXES-1:0] den;
        logic   [NAXES-1:0] dz;
        logic               miss;
        t_tnum              tn0;
        t_tden              td0;
        t_tnum              tn1;
        t_tden              td1;
    } t_ray;

    typedef struct packed {
        t_coord [NAXES-1:0] o;
        logic   [NAXES-1:0] dneg;
        logic               hit;
    } t_side;

    typedef struct packed {
        logic [NAXES-1:0][NW-1:0] num;
        logic [RW-1:0]            dv;
        t_side                    side;
    } t_div_in;

    typedef struct packed {
        logic [NAXES-1:0][QW-1:0] q;
        t_side                    side;
    } t_div_out;

endpackage

### src/rbsi_clip.sv
module rbsi_clip #(
    parameter int AXIS = rbsi_pkg::AXIS_X
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  rbsi_pkg::t_ray i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output rbsi_pkg::t_ray o_data
);
    import rbsi_pkg::*;

    logic r_v0, r_v1;
    t_ray r_ray0, r_ray1, n_ray1;
    logic signed [XW-1:0] r_pe_a, r_pe_b, r_px_a, r_px_b;
    logic en;

    assign en      = !r_v1 || i_ready;
    assign o_ready = en;
    assign o_valid = r_v1;
    assign o_data  = r_ray1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
        end
    end

    // stage 0: cross products for the entry and exit compares
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ray0 <= i_data;
            r_pe_a <= $signed(i_data.en[AXIS]) * $signed({1'b0, i_data.td0});
            r_pe_b <= $signed(i_data.tn0) * $signed({1'b0, i_data.den[AXIS]});
            r_px_a <= $signed(i_data.ex[AXIS]) * $signed({1'b0, i_data.td1});
            r_px_b <= $signed(i_data.tn1) * $signed({1'b0, i_data.den[AXIS]});
            r_ray1 <= n_ray1;
        end
    end

    // stage 1: tighten the interval; a flat axis leaves it alone
    always_comb begin
        n_ray1 = r_ray0;
        if (!r_ray0.dz[AXIS]) begin
            if (r_pe_a > r_pe_b) begin
                n_ray1.tn0 = r_ray0.en[AXIS];
                n_ray1.td0 = r_ray0.den[AXIS];
            end
            if (r_px_a < r_px_b) begin
                n_ray1.tn1 = r_ray0.ex[AXIS];
                n_ray1.td1 = r_ray0.den[AXIS];
            end
        end
    end

endmodule

### src/rbsi_div.sv
module rbsi_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  rbsi_pkg::t_div_in  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output rbsi_pkg::t_div_out o_data
);
    import rbsi_pkg::*;

    // restoring divider, one quotient bit per stage, three lanes share the divisor
    logic [QW-1:0] r_v;
    logic en;

    logic [NAXES-1:0][RW-1:0] r_rem [QW];
    logic [NAXES-1:0][QW-1:0] r_low [QW];
    logic [NAXES-1:0][QW-1:0] r_q   [QW];
    logic [RW-1:0]            r_dv  [QW];
    t_side                    r_side[QW];

    logic [NAXES-1:0][RW-1:0] s_rem [QW];
    logic [NAXES-1:0][QW-1:0] s_low [QW];
    logic [NAXES-1:0][QW-1:0] s_q   [QW];
    logic [RW-1:0]            s_dv  [QW];
    t_side                    s_side[QW];

    logic [NAXES-1:0][RW-1:0] n_rem [QW];
    logic [NAXES-1:0][QW-1:0] n_low [QW];
    logic [NAXES-1:0][QW-1:0] n_q   [QW];

    assign en      = !r_v[QW-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_v[QW-1];
    assign o_data  = '{q: r_q[QW-1], side: r_side[QW-1]};

    always_comb begin
        for (int a = 0; a < NAXES; a++) begin
            s_rem[0][a] = i_data.num[a][NW-1:QW];
            s_low[0][a] = i_data.num[a][QW-1:0];
            s_q[0][a]   = '0;
        end
        s_dv[0]   = i_data.dv;
        s_side[0] = i_data.side;
        for (int k = 1; k < QW; k++) begin
            s_rem[k]  = r_rem[k-1];
            s_low[k]  = r_low[k-1];
            s_q[k]    = r_q[k-1];
            s_dv[k]   = r_dv[k-1];
            s_side[k] = r_side[k-1];
        end
    end

    always_comb begin
        logic [RW:0] trial;
        for (int k = 0; k < QW; k++) begin
            for (int a = 0; a < NAXES; a++) begin
                trial = {s_rem[k][a], s_low[k][a][QW-1]};
                if (trial >= {1'b0, s_dv[k]}) begin
                    n_rem[k][a] = RW'(trial - {1'b0, s_dv[k]});
                    n_q[k][a]   = {s_q[k][a][QW-2:0], 1'b1};
                end else begin
                    n_rem[k][a] = trial[RW-1:0];
                    n_q[k][a]   = {s_q[k][a][QW-2:0], 1'b0};
                end
                n_low[k][a] = {s_low[k][a][QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[QW-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < QW; k++) begin
                r_rem[k]  <= n_rem[k];
                r_low[k]  <= n_low[k];
                r_q[k]    <= n_q[k];
                r_dv[k]   <= s_dv[k];
                r_side[k] <= s_side[k];
            end
        end
    end

endmodule

### src/ray_box_slab_intersect.sv
// Depth: 44 register stages; one transaction per cycle is accepted unless
// m_axis_tready holds the output. The 33-stage quotient pipeline of the
// entry-point divider and the three two-stage slab clippers set the depth.
// Reset (i_rst_n low, synchronous): pipeline emptied, wall height back to 2.0.
// Wall height is sampled as an item enters; write it only while idle.
module ray_box_slab_intersect (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rbsi_pkg::WH_WIDTH-1:0] i_cfg_wdata,   // wall_height, unsigned Q15.16
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // origin_x, origin_y, origin_z, end_x, end_y, end_z,
    // box_min_x, box_min_z, box_max_x, box_max_z (lowest bits first)
    input  logic [rbsi_pkg::IN_BITS-1:0]  s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // hit_x, hit_y, hit_z (lowest bits first)
    output logic [rbsi_pkg::OUT_BITS-1:0] m_axis_tdata,
    // hit
    output logic [0:0]                    m_axis_tuser
);
    import rbsi_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int SW = COORD_WIDTH + 2;

    logic [WH_WIDTH-1:0] r_wh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wh <= WH_RESET;
        end else if (i_cfg_we) begin
            r_wh <= i_cfg_wdata;
        end
    end

    // ---------------------------------------------------------------
    // Stage s1: direction, slab bounds, per-axis t numerators.
    // t runs over [0,1]; every t is kept as an exact fraction.
    // ---------------------------------------------------------------
    logic r_s1_v;
    t_ray r_s1, n_s1;
    logic en_s1;
    logic c0_ready;

    assign en_s1         = !r_s1_v || c0_ready;
    assign s_axis_tready = en_s1;

    always_comb begin
        logic signed [TW-1:0] o, e, bmin, bmax, lo, hi, d;
        n_s1      = '0;
        n_s1.tn0  = '0;
        n_s1.td0  = TW'(1);
        n_s1.tn1  = TW'(1);
        n_s1.td1  = TW'(1);
        for (int a = 0; a < NAXES; a++) begin
            o = TW'($signed(s_axis_tdata[a*CW +: CW]));
            e = TW'($signed(s_axis_tdata[(F_END_X+a)*CW +: CW]));
            case (a)
                AXIS_X: begin
                    bmin = TW'($signed(s_axis_tdata[F_BOX_MIN_X*CW +: CW]));
                    bmax = TW'($signed(s_axis_tdata[F_BOX_MAX_X*CW +: CW]));
                end
                AXIS_Z: begin
                    bmin = TW'($signed(s_axis_tdata[F_BOX_MIN_Z*CW +: CW]));
                    bmax = TW'($signed(s_axis_tdata[F_BOX_MAX_Z*CW +: CW]));
                end
                AXIS_Y: begin
                    bmin = '0;
                    bmax = $signed(TW'(r_wh));
                end
                default: begin
                    bmin = '0;
                    bmax = '0;
                end
            endcase
            // inverted bounds: slab spans between the two values
            lo = (bmin < bmax) ? bmin : bmax;
            hi = (bmin < bmax) ? bmax : bmin;
            d  = e - o;
            n_s1.o[a]  = s_axis_tdata[a*CW +: CW];
            n_s1.d[a]  = d;
            n_s1.dz[a] = (d == '0);
            if (d[TW-1]) begin
                n_s1.en[a]  = o - hi;
                n_s1.ex[a]  = o - lo;
                n_s1.den[a] = t_tden'(-d);
            end else begin
                n_s1.en[a]  = lo - o;
                n_s1.ex[a]  = hi - o;
                n_s1.den[a] = t_tden'(d);
            end
            // flat axis: origin must sit inside that slab
            if (d == '0 && (o < lo || o > hi)) begin
                n_s1.miss = 1'b1;
            end
        end
        // zero-length segment never hits
        if (&n_s1.dz) begin
            n_s1.miss = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (en_s1) begin
            r_s1_v <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_s1) begin
            r_s1 <= n_s1;
        end
    end

    // ---------------------------------------------------------------
    // Slab clippers, x then y then z, two stages each.
    // ---------------------------------------------------------------
    logic c0_v, c1_v, c2_v, c1_ready, c2_ready;
    t_ray c0_data, c1_data, c2_data;
    logic en_post;

    rbsi_clip #(.AXIS(AXIS_X)) u_clip_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s1_v),
        .o_ready (c0_ready),
        .i_data  (r_s1),
        .o_valid (c0_v),
        .i_ready (c1_ready),
        .o_data  (c0_data)
    );

    rbsi_clip #(.AXIS(AXIS_Y)) u_clip_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (c0_v),
        .o_ready (c1_ready),
        .i_data  (c0_data),
        .o_valid (c1_v),
        .i_ready (c2_ready),
        .o_data  (c1_data)
    );

    rbsi_clip #(.AXIS(AXIS_Z)) u_clip_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (c1_v),
        .o_ready (c2_ready),
        .i_data  (c1_data),
        .o_valid (c2_v),
        .i_ready (en_post),
        .o_data  (c2_data)
    );

    // ---------------------------------------------------------------
    // f1: cross products for t_enter <= t_exit
    // f2: hit decision, |d|
    // e1: |d| * t_enter numerator
    // ---------------------------------------------------------------
    logic r_f1_v, r_f2_v, r_e1_v;
    t_ray r_f1;
    logic signed [XW-1:0] r_c0, r_c1;
    logic r_f2_hit;
    t_tnum r_f2_tn0;
    t_tden r_f2_td0;
    logic [NAXES-1:0][TW-1:0] r_f2_mag, n_f2_mag;
    t_side r_f2_side, n_f2_side;
    logic [NAXES-1:0][PW-1:0] r_e1_p;
    t_tden r_e1_td0;
    t_side r_e1_side;
    logic div_ready;

    assign en_post = !r_e1_v || div_ready;

    always_comb begin
        n_f2_side.o   = r_f1.o;
        n_f2_side.hit = !r_f1.miss && !(r_c0 > r_c1);
        for (int a = 0; a < NAXES; a++) begin
            n_f2_side.dneg[a] = r_f1.d[a][TW-1];
            n_f2_mag[a]       = r_f1.d[a][TW-1] ? TW'(-r_f1.d[a]) : TW'(r_f1.d[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
            r_f2_v <= 1'b0;
            r_e1_v <= 1'b0;
        end else if (en_post) begin
            r_f1_v <= c2_v;
            r_f2_v <= r_f1_v;
            r_e1_v <= r_f2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_post) begin
            r_f1      <= c2_data;
            r_c0      <= $signed(c2_data.tn0) * $signed({1'b0, c2_data.td1});
            r_c1      <= $signed(c2_data.tn1) * $signed({1'b0, c2_data.td0});
            r_f2_hit  <= n_f2_side.hit;
            r_f2_tn0  <= r_f1.tn0;
            r_f2_td0  <= r_f1.td0;
            r_f2_mag  <= n_f2_mag;
            r_f2_side <= n_f2_side;
            for (int a = 0; a < NAXES; a++) begin
                r_e1_p[a] <= PW'(r_f2_mag[a]) * PW'($unsigned(r_f2_tn0));
            end
            r_e1_td0  <= r_f2_td0;
            r_e1_side <= r_f2_side;
        end
    end

    // ---------------------------------------------------------------
    // Entry offset = round(|d| * tn0 / td0), ties away from zero:
    // floor((2 * |d| * tn0 + td0) / (2 * td0)).
    // ---------------------------------------------------------------
    t_div_in  div_in;
    t_div_out div_out;
    logic     div_v;
    logic     en_out;

    always_comb begin
        for (int a = 0; a < NAXES; a++) begin
            div_in.num[a] = {r_e1_p[a], 1'b0} + NW'(r_e1_td0);
        end
        div_in.dv   = {r_e1_td0, 1'b0};
        div_in.side = r_e1_side;
    end

    rbsi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_e1_v),
        .o_ready (div_ready),
        .i_data  (div_in),
        .o_valid (div_v),
        .i_ready (en_out),
        .o_data  (div_out)
    );

    // ---------------------------------------------------------------
    // Output register: origin +/- offset, saturated; zeros on a miss.
    // ---------------------------------------------------------------
    logic r_out_v;
    logic r_out_hit;
    logic [NAXES-1:0][CW-1:0] r_out_c, n_out_c;

    assign en_out = !r_out_v || m_axis_tready;

    always_comb begin
        logic signed [SW-1:0] so, sq, sum;
        for (int a = 0; a < NAXES; a++) begin
            so  = SW'($signed(div_out.side.o[a]));
            sq  = $signed({1'b0, div_out.q[a]});
            sum = div_out.side.dneg[a] ? (so - sq) : (so + sq);
            if (!div_out.side.hit) begin
                n_out_c[a] = '0;
            end else if (sum[SW-1:CW-1] != '0 && sum[SW-1:CW-1] != '1) begin
                n_out_c[a] = sum[SW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
            end else begin
                n_out_c[a] = sum[CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en_out) begin
            r_out_v <= div_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_out_hit <= div_out.side.hit;
            r_out_c   <= n_out_c;
        end
    end

    assign m_axis_tvalid   = r_out_v;
    assign m_axis_tdata    = r_out_c;
    assign m_axis_tuser[0] = r_out_hit;

`ifndef SYNTHESIS
    // a miss carries an all-zero point
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("miss transaction with nonzero point");

    // entry t of a hit lies in [0,1]
    a_t_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_f2_v && r_f2_hit) |-> (!r_f2_tn0[TW-1] && (TW'($unsigned(r_f2_tn0)) <= r_f2_td0)))
        else $error("entry t outside [0,1] on a hit");

    // divisor never zero
    a_td_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_f1_v |-> (r_f1.td0 != '0))
        else $error("zero t denominator");

    // an output held under backpressure keeps its hit flag
    a_hold_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tuser))
        else $error("hit flag changed while stalled");
`endif

endmodule

### tb/tb_top.sv
module tb_top;
    import rbsi_pkg::*;

    // one incoming transaction: segment plus box bounds on x and z
    typedef struct {
        t_coord ox, oy, oz, ex, ey, ez, bminx, bminz, bmaxx, bmaxz;
    } t_seg_box;

    // one outgoing transaction: hit flag and entry point
    typedef struct {
        logic   hit;
        t_coord px, py, pz;
    } t_entry;

    // Keeps its own copy of the wall height and the queue of expected entries.
    class slab_scoreboard;
        logic [WH_WIDTH-1:0] wall_height = WH_RESET;
        t_entry              pending[$];
        int                  fails = 0;

        // a/b > c/e with b and e positive
        static function automatic bit frac_gt(longint a, longint b, longint c, longint e);
            logic signed [127:0] a1, b1, c1, e1;
            a1 = a; b1 = b; c1 = c; e1 = e;
            return (a1 * e1) > (c1 * b1);
        endfunction

        function automatic t_entry slab_test(t_seg_box it);
            longint o[3], d[3], lo[3], hi[3];
            longint tn0, td0, tn1, td1, en, ex, den, mg, v;
            logic [127:0] num, q;
            t_entry r;
            bit ok;
            tn0 = 0; td0 = 1; tn1 = 1; td1 = 1;
            o[0] = it.ox; o[1] = it.oy; o[2] = it.oz;
            d[0] = longint'(it.ex) - o[0];
            d[1] = longint'(it.ey) - o[1];
            d[2] = longint'(it.ez) - o[2];
            // inverted bounds: slab spans between the two values
            lo[0] = (it.bminx < it.bmaxx) ? it.bminx : it.bmaxx;
            hi[0] = (it.bminx < it.bmaxx) ? it.bmaxx : it.bminx;
            lo[1] = 0;
            hi[1] = longint'(wall_height);
            lo[2] = (it.bminz < it.bmaxz) ? it.bminz : it.bmaxz;
            hi[2] = (it.bminz < it.bmaxz) ? it.bmaxz : it.bminz;
            ok = !(d[0] == 0 && d[1] == 0 && d[2] == 0);
            for (int i = 0; i < NAXES; i++) begin
                if (!ok) break;
                if (d[i] == 0) begin
                    // flat axis: origin must sit in the slab
                    ok = o[i] >= lo[i] && o[i] <= hi[i];
                end else begin
                    if (d[i] > 0) begin
                        en = lo[i] - o[i]; ex = hi[i] - o[i]; den = d[i];
                    end else begin
                        en = o[i] - hi[i]; ex = o[i] - lo[i]; den = -d[i];
                    end
                    if (frac_gt(en, den, tn0, td0)) begin
                        tn0 = en; td0 = den;
                    end
                    if (frac_gt(tn1, td1, ex, den)) begin
                        tn1 = ex; td1 = den;
                    end
                end
            end
            if (ok) ok = !frac_gt(tn0, td0, tn1, td1);
            r = '{hit: 1'b0, px: '0, py: '0, pz: '0};
            if (!ok) return r;
            r.hit = 1'b1;
            for (int i = 0; i < NAXES; i++) begin
                mg  = (d[i] < 0) ? -d[i] : d[i];
                // round to nearest, ties away from zero
                num = 128'(mg) * 128'(tn0) * 2 + 128'(td0);
                q   = num / (128'(td0) * 2);
                v   = (d[i] < 0) ? o[i] - longint'(q) : o[i] + longint'(q);
                if (v > 64'sd2147483647) v = 64'sd2147483647;
                if (v < -64'sd2147483648) v = -64'sd2147483648;
                case (i)
                    AXIS_X: r.px = t_coord'(v);
                    AXIS_Y: r.py = t_coord'(v);
                    default: r.pz = t_coord'(v);
                endcase
            end
            return r;
        endfunction

        function void note_input(t_seg_box it);
            pending = {pending, slab_test(it)};
        endfunction

        function void check_result(logic [OUT_BITS-1:0] data, logic hit);
            t_entry e;
            t_coord ax, ay, az;
            if (pending.size() == 0) begin
                $error("result with nothing expected: hit=%0b data=%h", hit, data);
                fails++;
                return;
            end
            e  = pending.pop_front();
            ax = data[AXIS_X*COORD_WIDTH +: COORD_WIDTH];
            ay = data[AXIS_Y*COORD_WIDTH +: COORD_WIDTH];
            az = data[AXIS_Z*COORD_WIDTH +: COORD_WIDTH];
            if (hit !== e.hit) begin
                $error("hit: expected %0b actual %0b", e.hit, hit); fails++;
            end
            if (ax !== e.px) begin
                $error("hit_x: expected %0d actual %0d", e.px, ax); fails++;
            end
            if (ay !== e.py) begin
                $error("hit_y: expected %0d actual %0d", e.py, ay); fails++;
            end
            if (az !== e.pz) begin
                $error("hit_z: expected %0d actual %0d", e.pz, az); fails++;
            end
        endfunction
    endclass

    localparam int LATENCY = 44;
    localparam int N_RANDOM = 1000;
    localparam t_coord ONE = 32'sd65536;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [WH_WIDTH-1:0] i_cfg_wdata = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [IN_BITS-1:0]  s_axis_tdata = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OUT_BITS-1:0] m_axis_tdata;
    logic [0:0]          m_axis_tuser;

    slab_scoreboard sb = new();

    bit calm      = 1'b0;  // end of run: no idling on either side
    bit hold_req  = 1'b0;  // sender asks the receiver for a long hold-off
    bit hold_done = 1'b0;

    ray_box_slab_intersect u_top (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // fixed-time guard
    initial begin
        #4000000;
        $display("tb: failure");
        $finish;
    end

    // output side: transaction taken when tvalid and tready were both high before the edge
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser[0]);
    end

    // receiver ready: random stall bursts, one long hold-off on request
    initial begin
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_req && !hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_done = 1'b1;
            end else if (!calm && $urandom_range(0, 9) < 2) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    function automatic logic [IN_BITS-1:0] pack_item(t_seg_box it);
        return {it.bmaxz, it.bmaxx, it.bminz, it.bminx,
                it.ez, it.ey, it.ex, it.oz, it.oy, it.ox};
    endfunction

    // hold valid until the transaction is taken; the next send or an idle
    // gap decides what valid does afterwards
    task automatic send_item(t_seg_box it);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_item(it);
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_input(it);
        if (!calm && !hold_req && $urandom_range(0, 9) < 2) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_wall(logic [WH_WIDTH-1:0] value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.wall_height = value;
    endtask

    function automatic t_coord rnd_full();
        return t_coord'($urandom());
    endfunction

    // coordinate near the box, with a random fraction
    function automatic t_coord rnd_near(int span);
        return t_coord'((longint'($urandom_range(0, 2 * span)) - span) * ONE
                        + longint'($urandom_range(0, 65535)));
    endfunction

    function automatic t_seg_box rnd_item();
        t_seg_box it;
        int mode;
        mode = $urandom_range(0, 9);
        if (mode == 0) begin
            // noise over the whole range
            it = '{rnd_full(), rnd_full(), rnd_full(), rnd_full(), rnd_full(),
                   rnd_full(), rnd_full(), rnd_full(), rnd_full(), rnd_full()};
        end else begin
            it.bminx = rnd_near(8); it.bmaxx = rnd_near(8);
            it.bminz = rnd_near(8); it.bmaxz = rnd_near(8);
            if ($urandom_range(0, 3) != 0) begin
                if (it.bminx > it.bmaxx) {it.bminx, it.bmaxx} = {it.bmaxx, it.bminx};
                if (it.bminz > it.bmaxz) {it.bminz, it.bmaxz} = {it.bmaxz, it.bminz};
            end
            it.ox = rnd_near(12); it.oy = rnd_near(4); it.oz = rnd_near(12);
            it.ex = rnd_near(12); it.ey = rnd_near(4); it.ez = rnd_near(12);
            // flat axes and integer grid points give touching and slab-edge cases
            if (mode == 1) it.ex = it.ox;
            if (mode == 2) it.ey = it.oy;
            if (mode == 3) it.ez = it.oz;
            if (mode == 4) begin
                it.ox = it.ox & ~32'hffff; it.ex = it.bminx;
                it.oz = it.bmaxz;          it.ez = it.ez & ~32'hffff;
            end
            if (mode == 5) begin
                it = '{it.ox, it.oy, it.oz, rnd_full(), rnd_full(), rnd_full(),
                       it.bminx, it.bminz, it.bmaxx, it.bmaxz};
            end
        end
        return it;
    endfunction

    task automatic directed_items();
        t_coord mx, mn;
        mx = 32'sh7fffffff;
        mn = 32'sh80000000;
        // plain hit through a unit box
        send_item('{-4*ONE, ONE, 0, 4*ONE, ONE, 0, -ONE, -ONE, ONE, ONE});
        // zero-length segment inside the box
        send_item('{0, ONE, 0, 0, ONE, 0, -ONE, -ONE, ONE, ONE});
        // flat x axis, origin outside the slab
        send_item('{3*ONE, ONE, -4*ONE, 3*ONE, ONE, 4*ONE, -ONE, -ONE, ONE, ONE});
        // flat x axis, origin on the slab face
        send_item('{ONE, ONE, -4*ONE, ONE, ONE, 4*ONE, -ONE, -ONE, ONE, ONE});
        // inverted bounds
        send_item('{-4*ONE, ONE, 0, 4*ONE, ONE, 0, ONE, ONE, -ONE, -ONE});
        // origin inside
        send_item('{0, ONE, 0, 5*ONE, 3*ONE, 7*ONE, -ONE, -ONE, ONE, ONE});
        // entering exactly through a corner edge of the box
        send_item('{-2*ONE, ONE, 0, 0, ONE, 2*ONE, -ONE, ONE, ONE, 3*ONE});
        // segment stops short of the box
        send_item('{-4*ONE, ONE, 0, -2*ONE, ONE, 0, -ONE, -ONE, ONE, ONE});
        // negative direction, rounding
        send_item('{5*ONE+3, 3*ONE, ONE+1, -3*ONE, -ONE+7, -ONE, -ONE, -ONE, ONE, ONE});
        // coordinate extremes
        send_item('{mn, mn, mn, mx, mx, mx, mn, mn, mx, mx});
        send_item('{mx, mx, mx, mn, mn, mn, mn, mn, mx, mx});
        send_item('{mn, 0, mx, mx, 0, mn, mn, mn, mx, mx});
        send_item('{mx, mx, mx, mx, mx, mx, mx, mx, mx, mx});
        send_item('{mn, -1, mn, mx, 1, mx, 0, 0, 0, 0});
        send_item('{-1, -1, -1, 0, 0, 0, -1, -1, -1, -1});
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        directed_items();
        // wall height settings, extremes included
        write_wall(WH_WIDTH'(0));
        directed_items();
        write_wall({WH_WIDTH{1'b1}});
        directed_items();
        write_wall(WH_WIDTH'(3) << FRAC_BITS);
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 250) hold_req = 1'b1;   // receiver holds while we keep offering
            if (n == 450) begin
                hold_req = 1'b0;
                drain();                     // pause until every result is back
            end
            if (n == 500) write_wall(WH_WIDTH'($urandom_range(0, 6 << FRAC_BITS)));
            if (n == 700) write_wall(WH_WIDTH'($urandom()));
            if (n == 750) write_wall(WH_RESET);
            if (n == 900) calm = 1'b1;
            send_item(rnd_item());
        end
        drain();
        if (sb.pending.size() != 0) sb.fails++;
        if (sb.fails == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### files.f
src/rbsi_pkg.sv
src/rbsi_clip.sv
src/rbsi_div.sv
src/ray_box_slab_intersect.sv
tb/tb_top.sv
